FILE: hdl/fcsm_pkg.sv
package fcsm_pkg;

	localparam int ScoreMaxDefault = 3;

	localparam logic [15:0] VerifyTimeoutReset = 16'd8000;
	localparam logic [15:0] StillConfirmReset  = 16'd1500;
	localparam logic [15:0] MoveCancelReset    = 16'd3000;
	localparam logic [15:0] CancelHoldReset    = 16'd3000;
	localparam logic [1:0]  EnterThreshReset   = 2'd2;

	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 16;

	localparam logic [CfgIndexW-1:0] REG_VERIFY_TIMEOUT = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_STILL_CONFIRM  = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_MOVE_CANCEL    = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_CANCEL_HOLD    = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_ENTER_THRESH   = 3'd4;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_CANCEL = 1'b1;

	localparam logic [1:0] FS_IDLE      = 2'd0;
	localparam logic [1:0] FS_VERIFY    = 2'd1;
	localparam logic [1:0] FS_CONFIRMED = 2'd2;
	localparam logic [1:0] FS_CANCELLED = 2'd3;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'b0001,
		PH_VERIFY    = 4'b0010,
		PH_CONFIRMED = 4'b0100,
		PH_CANCELLED = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [15:0] verify_window_ms;
		logic [15:0] still_confirm_ms;
		logic [15:0] move_abort_ms;
		logic [15:0] cancel_hold_ms;
		logic [1:0]  enter_threshold;
	} cfg_t;

	typedef struct packed {
		logic        opcode;
		logic [31:0] now_ms;
		logic        fall_candidate;
		logic        moving;
		logic        still;
	} item_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] verify_start;
		logic [31:0] still_start;
		logic [31:0] move_start;
		logic [31:0] cancel_start;
	} mach_t;

	localparam mach_t MachClear = '{
		phase:        PH_IDLE,
		verify_start: 32'd0,
		still_start:  32'd0,
		move_start:   32'd0,
		cancel_start: 32'd0
	};

endpackage

FILE: hdl/fcsm_if.sv
interface fcsm_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] now_ms;
	logic        fall_candidate;
	logic        moving;
	logic        still;

	modport source (output valid, opcode, now_ms, fall_candidate, moving, still, input ready);
	modport sink (input valid, opcode, now_ms, fall_candidate, moving, still, output ready);
endinterface

interface fcsm_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] fall_state;
	logic       detected;
	logic       confirmed;
	logic [1:0] probability_thirds;
	logic [1:0] score;

	modport source (output valid, fall_state, detected, confirmed, probability_thirds, score,
		input ready);
	modport sink (input valid, fall_state, detected, confirmed, probability_thirds, score,
		output ready);
endinterface

FILE: hdl/fcsm_step.sv
module fcsm_step #(
	parameter int ScoreMax = fcsm_pkg::ScoreMaxDefault,
	parameter int ScoreW   = $clog2(ScoreMax + 1)
) (
	input  fcsm_pkg::cfg_t  cfg,
	input  fcsm_pkg::item_t item,
	input  fcsm_pkg::mach_t cur,
	input  logic [ScoreW-1:0] cur_score,
	output fcsm_pkg::mach_t nxt,
	output logic [ScoreW-1:0] nxt_score
);

	localparam int CmpW = (ScoreW > 2) ? ScoreW : 2;

	logic [ScoreW-1:0] upd_score;
	logic [31:0]       el_move;
	logic [31:0]       el_still;

	always_comb begin
		if (item.fall_candidate) begin
			upd_score = (cur_score < ScoreW'(ScoreMax)) ? cur_score + ScoreW'(1) : cur_score;
		end else begin
			upd_score = (cur_score != '0) ? cur_score - ScoreW'(1) : cur_score;
		end
	end

	always_comb begin
		nxt       = cur;
		nxt_score = cur_score;
		el_move   = '0;
		el_still  = '0;
		if (item.opcode == fcsm_pkg::OP_CANCEL) begin
			nxt.phase        = fcsm_pkg::PH_CANCELLED;
			nxt.cancel_start = item.now_ms;
			nxt_score        = '0;
		end else begin
			unique case (cur.phase)
				fcsm_pkg::PH_CANCELLED: begin
					if ((item.now_ms - cur.cancel_start) > {16'd0, cfg.cancel_hold_ms}) begin
						nxt       = fcsm_pkg::MachClear;
						nxt_score = '0;
					end
				end
				fcsm_pkg::PH_CONFIRMED: begin
				end
				fcsm_pkg::PH_IDLE: begin
					nxt_score = upd_score;
					if (CmpW'(upd_score) >= CmpW'(cfg.enter_threshold)) begin
						nxt.phase        = fcsm_pkg::PH_VERIFY;
						nxt.verify_start = item.now_ms;
						nxt.still_start  = '0;
						nxt.move_start   = '0;
					end
				end
				fcsm_pkg::PH_VERIFY: begin
					nxt_score = upd_score;
					if ((item.now_ms - cur.verify_start) > {16'd0, cfg.verify_window_ms}) begin
						nxt       = fcsm_pkg::MachClear;
						nxt_score = '0;
					end else begin
						if (item.moving) begin
							if (nxt.move_start == '0) begin
								nxt.move_start = item.now_ms;
							end
							el_move = item.now_ms - nxt.move_start;
							if (el_move > {16'd0, cfg.move_abort_ms}) begin
								nxt       = fcsm_pkg::MachClear;
								nxt_score = '0;
							end
						end else begin
							nxt.move_start = '0;
						end
						if (item.still) begin
							if (nxt.still_start == '0) begin
								nxt.still_start = item.now_ms;
							end
							el_still = item.now_ms - nxt.still_start;
							if (el_still >= {16'd0, cfg.still_confirm_ms}) begin
								nxt.phase = fcsm_pkg::PH_CONFIRMED;
							end
						end else begin
							nxt.still_start = '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: hdl/fall_confirm_state_machine.sv
// Channel   Dir  Payload                                              Transfer
// sample    in   opcode, now_ms, fall_candidate, moving, still         valid & ready
// result    out  fall_state, detected, confirmed, probability_thirds,  valid & ready
//                score
// config    in   cfg_index, cfg_data                                  cfg_we
//
// Each sample is turned into its result by the step logic and registered: the step
// logic reads the machine registers and the result register is loaded at the same edge.
// A new sample is taken every cycle while the result register is empty or drained.
// Reset puts the machine in idle and the config, score and valid registers at their defaults.
// A stalled result holds the sample side until it is transferred.
module fall_confirm_state_machine #(
	parameter int ScoreMax = fcsm_pkg::ScoreMaxDefault
) (
	input  logic clk,
	input  logic arst_n,
	fcsm_in_if.sink    sample,
	fcsm_out_if.source result,
	input  logic                           cfg_we,
	input  logic [fcsm_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [fcsm_pkg::CfgDataW-1:0]  cfg_data
);

	localparam int ScoreW = $clog2(ScoreMax + 1);
	localparam int CmpW   = (ScoreW > 2) ? ScoreW : 2;
	localparam int PrW    = ScoreW + 2;

	fcsm_pkg::cfg_t    cfg_q;
	fcsm_pkg::mach_t   mach_q;
	fcsm_pkg::mach_t   mach_d;
	fcsm_pkg::item_t   item;
	logic [ScoreW-1:0] score_q;
	logic [ScoreW-1:0] score_d;
	logic              accept;
	logic              out_valid_q;
	logic [PrW-1:0]    prod_d;
	logic [1:0]        fs_d;
	logic [1:0]        prob_d;
	logic [1:0]        sat_d;
	logic [1:0]        fs_q;
	logic [1:0]        prob_q;
	logic [1:0]        sat_q;

	assign item = '{
		opcode:         sample.opcode,
		now_ms:         sample.now_ms,
		fall_candidate: sample.fall_candidate,
		moving:         sample.moving,
		still:          sample.still
	};

	assign sample.ready = !out_valid_q || result.ready;
	assign accept       = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.verify_window_ms <= fcsm_pkg::VerifyTimeoutReset;
			cfg_q.still_confirm_ms <= fcsm_pkg::StillConfirmReset;
			cfg_q.move_abort_ms    <= fcsm_pkg::MoveCancelReset;
			cfg_q.cancel_hold_ms   <= fcsm_pkg::CancelHoldReset;
			cfg_q.enter_threshold  <= fcsm_pkg::EnterThreshReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fcsm_pkg::REG_VERIFY_TIMEOUT: cfg_q.verify_window_ms <= cfg_data;
				fcsm_pkg::REG_STILL_CONFIRM:  cfg_q.still_confirm_ms <= cfg_data;
				fcsm_pkg::REG_MOVE_CANCEL:    cfg_q.move_abort_ms    <= cfg_data;
				fcsm_pkg::REG_CANCEL_HOLD:    cfg_q.cancel_hold_ms   <= cfg_data;
				fcsm_pkg::REG_ENTER_THRESH:   cfg_q.enter_threshold  <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	fcsm_step #(
		.ScoreMax(ScoreMax),
		.ScoreW(ScoreW)
	) u_step (
		.cfg(cfg_q),
		.item(item),
		.cur(mach_q),
		.cur_score(score_q),
		.nxt(mach_d),
		.nxt_score(score_d)
	);

	always_comb begin
		unique case (mach_d.phase)
			fcsm_pkg::PH_IDLE:      fs_d = fcsm_pkg::FS_IDLE;
			fcsm_pkg::PH_VERIFY:    fs_d = fcsm_pkg::FS_VERIFY;
			fcsm_pkg::PH_CONFIRMED: fs_d = fcsm_pkg::FS_CONFIRMED;
			fcsm_pkg::PH_CANCELLED: fs_d = fcsm_pkg::FS_CANCELLED;
			default:                fs_d = fcsm_pkg::FS_IDLE;
		endcase
	end

	// Outside the confirmed phase, where it is 3, the probability in thirds counts how many
	// of ScoreMax, 2*ScoreMax and 3*ScoreMax the tripled score reaches.
	always_comb begin
		prod_d = PrW'(3) * PrW'(score_d);
		if (mach_d.phase == fcsm_pkg::PH_CONFIRMED) begin
			prob_d = 2'd3;
		end else begin
			prob_d = {1'b0, prod_d >= PrW'(ScoreMax)}
				+ {1'b0, prod_d >= PrW'(2 * ScoreMax)}
				+ {1'b0, prod_d >= PrW'(3 * ScoreMax)};
		end
		sat_d = (CmpW'(score_d) > CmpW'(3)) ? 2'd3 : 2'(score_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mach_q      <= fcsm_pkg::MachClear;
			score_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mach_q  <= mach_d;
				score_q <= score_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fs_q   <= fs_d;
			prob_q <= prob_d;
			sat_q  <= sat_d;
		end
	end

	assign result.valid              = out_valid_q;
	assign result.fall_state         = fs_q;
	assign result.detected           = (fs_q == fcsm_pkg::FS_VERIFY);
	assign result.confirmed          = (fs_q == fcsm_pkg::FS_CONFIRMED);
	assign result.probability_thirds = prob_q;
	assign result.score              = sat_q;

endmodule

FILE: test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fcsm_pkg::*;

	localparam int ScoreMax = ScoreMaxDefault;
	localparam int PhaseCount = 8;
	localparam int ItemsPerPhase = 172;

	typedef struct packed {
		logic [1:0] fall_state;
		logic       detected;
		logic       confirmed;
		logic [1:0] probability_thirds;
		logic [1:0] score;
	} status_t;

	typedef struct packed {
		logic        op;
		logic [31:0] now;
		logic        cand;
		logic        mov;
		logic        stl;
		logic        typed;
		logic [1:0]  fall_state;
		logic        det;
		logic        conf;
		logic [1:0]  prob;
		logic [1:0]  sc;
	} row_t;

	logic clk;
	logic arst_n;
	logic                 cfg_we;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0]  cfg_data;

	fcsm_in_if  sample_ch ();
	fcsm_out_if result_ch ();

	fall_confirm_state_machine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Machine copy kept by the testbench.
	logic [1:0]  m_phase;
	logic        m_det;
	logic        m_conf;
	int          m_score;
	logic [31:0] m_verify_at;
	logic [31:0] m_still_at;
	logic [31:0] m_move_at;
	logic [31:0] m_cancel_at;
	logic [15:0] lim_verify;
	logic [15:0] lim_still;
	logic [15:0] lim_move;
	logic [15:0] lim_hold;
	logic [1:0]  enter_thr;

	status_t due_status [$];

	int n_mismatch;
	int n_items;
	int n_cancel;
	int n_confirm;
	bit tx_calm;
	bit rx_calm;

	logic [CfgIndexW-1:0] reg_order [5] = '{REG_VERIFY_TIMEOUT, REG_STILL_CONFIRM,
		REG_MOVE_CANCEL, REG_CANCEL_HOLD, REG_ENTER_THRESH};

	row_t directed_rows [21] = '{
		'{OP_UPDATE, 32'd100, 1'b0, 1'b0, 1'b0, 1'b1, FS_IDLE, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_UPDATE, 32'd200, 1'b1, 1'b0, 1'b0, 1'b1, FS_IDLE, 1'b0, 1'b0, 2'd1, 2'd1},
		'{OP_UPDATE, 32'd300, 1'b1, 1'b0, 1'b0, 1'b1, FS_VERIFY, 1'b1, 1'b0, 2'd2, 2'd2},
		'{OP_UPDATE, 32'd400, 1'b1, 1'b0, 1'b1, 1'b0, FS_IDLE, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_UPDATE, 32'd1900, 1'b1, 1'b0, 1'b1, 1'b1, FS_CONFIRMED, 1'b0, 1'b1, 2'd3, 2'd3},
		'{OP_UPDATE, 32'd2000, 1'b0, 1'b1, 1'b0, 1'b1, FS_CONFIRMED, 1'b0, 1'b1, 2'd3, 2'd3},
		'{OP_CANCEL, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, FS_CANCELLED, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_UPDATE, 32'd2999, 1'b1, 1'b0, 1'b0, 1'b1, FS_CANCELLED, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_UPDATE, 32'd3000, 1'b1, 1'b0, 1'b0, 1'b1, FS_IDLE, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_UPDATE, 32'd4000, 1'b1, 1'b1, 1'b1, 1'b0, FS_IDLE, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_UPDATE, 32'd4100, 1'b1, 1'b1, 1'b0, 1'b0, FS_IDLE, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_UPDATE, 32'd4200, 1'b1, 1'b1, 1'b0, 1'b0, FS_IDLE, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_UPDATE, 32'd7201, 1'b1, 1'b1, 1'b1, 1'b1, FS_IDLE, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_UPDATE, 32'd0, 1'b1, 1'b0, 1'b0, 1'b0, FS_IDLE, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_UPDATE, 32'd0, 1'b1, 1'b0, 1'b0, 1'b0, FS_IDLE, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_UPDATE, 32'd0, 1'b1, 1'b0, 1'b1, 1'b0, FS_IDLE, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_UPDATE, 32'd1500, 1'b1, 1'b0, 1'b1, 1'b0, FS_IDLE, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_UPDATE, 32'd8001, 1'b0, 1'b0, 1'b0, 1'b1, FS_IDLE, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_CANCEL, 32'd0, 1'b1, 1'b1, 1'b1, 1'b1, FS_CANCELLED, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_UPDATE, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1, FS_CANCELLED, 1'b0, 1'b0, 2'd0, 2'd0},
		'{OP_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, FS_IDLE, 1'b0, 1'b0, 2'd0, 2'd0}
	};

	always #4ns clk = ~clk;

	function automatic void clear_machine();
		m_phase     = FS_IDLE;
		m_det       = 1'b0;
		m_conf      = 1'b0;
		m_score     = 0;
		m_verify_at = '0;
		m_still_at  = '0;
		m_move_at   = '0;
		m_cancel_at = '0;
	endfunction

	function automatic status_t next_status(item_t it);
		status_t     s;
		logic [31:0] elapsed;
		int          prob;
		if (it.opcode == OP_CANCEL) begin
			m_phase     = FS_CANCELLED;
			m_det       = 1'b0;
			m_conf      = 1'b0;
			m_score     = 0;
			m_cancel_at = it.now_ms;
		end else if (m_phase == FS_CANCELLED) begin
			elapsed = it.now_ms - m_cancel_at;
			if (elapsed > {16'd0, lim_hold})
				clear_machine();
		end else if (m_phase != FS_CONFIRMED) begin
			if (it.fall_candidate) begin
				if (m_score < ScoreMax)
					m_score++;
			end else if (m_score > 0) begin
				m_score--;
			end
			if (m_phase == FS_IDLE) begin
				if (m_score >= int'(enter_thr)) begin
					m_phase     = FS_VERIFY;
					m_det       = 1'b1;
					m_conf      = 1'b0;
					m_verify_at = it.now_ms;
					m_still_at  = '0;
					m_move_at   = '0;
				end
			end else begin
				elapsed = it.now_ms - m_verify_at;
				if (elapsed > {16'd0, lim_verify}) begin
					clear_machine();
				end else begin
					if (it.moving) begin
						if (m_move_at == '0)
							m_move_at = it.now_ms;
						elapsed = it.now_ms - m_move_at;
						if (elapsed > {16'd0, lim_move})
							clear_machine();
					end else begin
						m_move_at = '0;
					end
					if (it.still) begin
						if (m_still_at == '0)
							m_still_at = it.now_ms;
						elapsed = it.now_ms - m_still_at;
						if (elapsed >= {16'd0, lim_still}) begin
							m_phase = FS_CONFIRMED;
							m_det   = 1'b0;
							m_conf  = 1'b1;
							n_confirm++;
						end
					end else begin
						m_still_at = '0;
					end
				end
			end
		end
		prob = m_conf ? 3 : (3 * m_score) / ScoreMax;
		if (prob > 3)
			prob = 3;
		s.fall_state         = m_phase;
		s.detected           = m_det;
		s.confirmed          = m_conf;
		s.probability_thirds = 2'(prob);
		s.score              = (m_score > 3) ? 2'd3 : 2'(m_score);
		return s;
	endfunction

	task automatic flag_mismatch(string msg);
		if (n_mismatch < 40)
			$display("%0t ns  mismatch: %s", $realtime, msg);
		n_mismatch++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	task automatic send_item(item_t it, logic typed, status_t typed_want);
		int      gap;
		status_t predicted;
		if ($urandom_range(0, 29) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid          <= 1'b1;
		sample_ch.opcode         <= it.opcode;
		sample_ch.now_ms         <= it.now_ms;
		sample_ch.fall_candidate <= it.fall_candidate;
		sample_ch.moving         <= it.moving;
		sample_ch.still          <= it.still;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		predicted = next_status(it);
		due_status.push_back(typed ? typed_want : predicted);
		n_items++;
		if (it.opcode == OP_CANCEL)
			n_cancel++;
	endtask

	initial begin
		int      stall;
		status_t got;
		status_t want;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 29) == 0)
				rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			got.fall_state         = result_ch.fall_state;
			got.detected           = result_ch.detected;
			got.confirmed          = result_ch.confirmed;
			got.probability_thirds = result_ch.probability_thirds;
			got.score              = result_ch.score;
			if (due_status.size() == 0) begin
				flag_mismatch("result transfer with nothing expected");
			end else begin
				want = due_status.pop_front();
				check_field("fall_state", got.fall_state, want.fall_state);
				check_field("detected", got.detected, want.detected);
				check_field("confirmed", got.confirmed, want.confirmed);
				check_field("probability_thirds", got.probability_thirds,
					want.probability_thirds);
				check_field("score", got.score, want.score);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		item_t       it;
		status_t     want;
		logic [15:0] vals [5];
		logic [31:0] clock_ms;
		int          step_max;
		int          roll;
		int          motion;
		bit          cand_hot;
		clk                      = 1'b0;
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_index                = '0;
		cfg_data                 = '0;
		sample_ch.valid          = 1'b0;
		sample_ch.opcode         = OP_UPDATE;
		sample_ch.now_ms         = '0;
		sample_ch.fall_candidate = 1'b0;
		sample_ch.moving         = 1'b0;
		sample_ch.still          = 1'b0;
		result_ch.ready          = 1'b0;
		lim_verify = VerifyTimeoutReset;
		lim_still  = StillConfirmReset;
		lim_move   = MoveCancelReset;
		lim_hold   = CancelHoldReset;
		enter_thr  = EnterThreshReset;
		clear_machine();
		n_mismatch = 0;
		n_items    = 0;
		n_cancel   = 0;
		n_confirm  = 0;
		tx_calm    = 1'b0;
		rx_calm    = 1'b0;
		clock_ms   = 32'd10;
		motion     = 0;
		cand_hot   = 1'b1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			it   = '{directed_rows[i].op, directed_rows[i].now, directed_rows[i].cand,
				directed_rows[i].mov, directed_rows[i].stl};
			want = '{directed_rows[i].fall_state, directed_rows[i].det,
				directed_rows[i].conf, directed_rows[i].prob, directed_rows[i].sc};
			send_item(it, directed_rows[i].typed, want);
		end
		sample_ch.valid <= 1'b0;

		for (int p = 0; p < PhaseCount; p++) begin
			while (due_status.size() != 0) @(posedge clk);
			case (p)
				0: vals = '{16'd1200, 16'd600, 16'd900, 16'd700, 16'd1};
				1: vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
				2: vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
				default: begin
					foreach (vals[k])
						vals[k] = ($urandom_range(0, 5) == 0) ? 16'($urandom)
							: 16'($urandom_range(0, 4000));
					vals[4] = 16'($urandom);
				end
			endcase
			step_max = (p == 1) ? 2 : (p == 2) ? 9000 : 700;
			for (int k = 0; k < 5; k++) begin
				cfg_we    <= 1'b1;
				cfg_index <= reg_order[k];
				cfg_data  <= vals[k];
				@(posedge clk);
				case (reg_order[k])
					REG_VERIFY_TIMEOUT: lim_verify = vals[k];
					REG_STILL_CONFIRM:  lim_still  = vals[k];
					REG_MOVE_CANCEL:    lim_move   = vals[k];
					REG_CANCEL_HOLD:    lim_hold   = vals[k];
					REG_ENTER_THRESH:   enter_thr  = vals[k][1:0];
					default: ;
				endcase
			end
			cfg_we <= 1'b0;

			for (int n = 0; n < ItemsPerPhase; n++) begin
				if ($urandom_range(0, 15) == 0)
					motion = $urandom_range(0, 2);
				if ($urandom_range(0, 19) == 0)
					cand_hot = ($urandom_range(0, 99) < 40);
				roll = $urandom_range(0, 99);
				if (roll < 2)
					clock_ms = $urandom;
				else if (roll < 3)
					clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 4000));
				else if (roll < 5)
					clock_ms = '0;
				else
					clock_ms = clock_ms + 32'($urandom_range(0, step_max));
				it.opcode         = ($urandom_range(0, 29) == 0) ? OP_CANCEL : OP_UPDATE;
				it.now_ms         = clock_ms;
				it.fall_candidate = cand_hot ? ($urandom_range(0, 9) < 8)
					: ($urandom_range(0, 9) < 2);
				case (motion)
					0: begin
						it.still  = 1'b1;
						it.moving = ($urandom_range(0, 9) == 0);
					end
					1: begin
						it.still  = 1'b0;
						it.moving = 1'b1;
					end
					default: begin
						it.still  = 1'($urandom);
						it.moving = 1'($urandom);
					end
				endcase
				send_item(it, 1'b0, '0);
			end
			sample_ch.valid <= 1'b0;
		end

		while (due_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		$display("Run covered %0d transfers over %0d register settings after reset.",
			n_items, PhaseCount);
		$display("It saw %0d cancels, %0d confirmations and %0d mismatches.",
			n_cancel, n_confirm, n_mismatch);
		if (n_mismatch == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
